>>> hdl/vertex_dedup_hash_table_defines.svh
// Assertion macros for the file that checks its own logic.
`ifndef VERTEX_DEDUP_HASH_TABLE_DEFINES_SVH
`define VERTEX_DEDUP_HASH_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VDH_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VDH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/vdh_pkg.sv
package vdh_pkg;

  // Depth of the slot table and of the vertex store is 1 << TABLE_BITS.
  localparam int TABLE_BITS = 12;
  localparam int SLOTS = 1 << TABLE_BITS;
  localparam int CNT_W = TABLE_BITS + 1;

  localparam int WORD_W = 32;
  localparam int INDEX_OUT_W = 12;
  localparam int COUNT_OUT_W = 13;
  localparam int TBITS_REG_W = 4;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_HASH_SEED = cfg_idx_t'(0);
  localparam cfg_idx_t REG_TABLE_BITS = cfg_idx_t'(1);

  localparam logic [WORD_W-1:0] SEED_RESET = 32'd133200997;
  localparam logic [TBITS_REG_W-1:0] TBITS_RESET = 4'd12;
  localparam logic [WORD_W-1:0] CANON_NAN = 32'h7FC0_0000;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } vertex_t;

  localparam int VERTEX_W = 3 * WORD_W;

  typedef struct packed {
    logic                  valid;
    logic [TABLE_BITS-1:0] index;
  } slot_entry_t;

  localparam int SLOT_W = TABLE_BITS + 1;

endpackage

>>> hdl/vdh_ram.sv
module vdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/vdh_hash.sv
module vdh_hash (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [vdh_pkg::WORD_W-1:0] seed,
  input  vdh_pkg::vertex_t       words,
  output logic                   done,
  output logic [vdh_pkg::WORD_W-1:0] hash
);

  import vdh_pkg::*;

  localparam logic [WORD_W-1:0] C1 = 32'hCC9E_2D51;
  localparam logic [WORD_W-1:0] C2 = 32'h1B87_3593;
  localparam logic [WORD_W-1:0] C3 = 32'h85EB_CA6B;
  localparam logic [WORD_W-1:0] C4 = 32'hC2B2_AE35;
  localparam logic [WORD_W-1:0] M5 = 32'd5;
  localparam logic [WORD_W-1:0] ADDC = 32'hE654_6B64;

  typedef enum logic [6:0] {
    H_IDLE = 7'b0000001,
    H_K1   = 7'b0000010,
    H_K2   = 7'b0000100,
    H_HMIX = 7'b0001000,
    H_F1   = 7'b0010000,
    H_F2   = 7'b0100000,
    H_F3   = 7'b1000000
  } hstate_t;

  hstate_t           state;
  logic [1:0]        wsel;
  logic [WORD_W-1:0] k;
  logic [WORD_W-1:0] h;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] mul_a;
  logic [WORD_W-1:0] mul_b;
  logic [WORD_W-1:0] mul_p;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int r);
    return (v << r) | (v >> (WORD_W - r));
  endfunction

  always_comb begin
    case (wsel)
      2'd0:    word = words.x;
      2'd1:    word = words.y;
      default: word = words.z;
    endcase
  end

  // The one multiplier; each step picks its operands.
  always_comb begin
    case (state)
      H_K1: begin
        mul_a = word;
        mul_b = C1;
      end
      H_K2: begin
        mul_a = rotl(k, 15);
        mul_b = C2;
      end
      H_HMIX: begin
        mul_a = rotl(h ^ k, 13);
        mul_b = M5;
      end
      H_F1: begin
        mul_a = h ^ (h >> 16);
        mul_b = C3;
      end
      H_F2: begin
        mul_a = h ^ (h >> 13);
        mul_b = C4;
      end
      default: begin
        mul_a = h;
        mul_b = M5;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign hash = h;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
      wsel  <= 2'd0;
    end else begin
      done <= 1'b0;
      case (state)
        H_IDLE: begin
          if (start) begin
            h     <= seed;
            wsel  <= 2'd0;
            state <= H_K1;
          end
        end
        H_K1: begin
          k     <= mul_p;
          state <= H_K2;
        end
        H_K2: begin
          k     <= mul_p;
          state <= H_HMIX;
        end
        H_HMIX: begin
          h <= mul_p + ADDC;
          if (wsel == 2'd2) begin
            state <= H_F1;
          end else begin
            wsel  <= wsel + 2'd1;
            state <= H_K1;
          end
        end
        H_F1: begin
          h     <= mul_p;
          state <= H_F2;
        end
        H_F2: begin
          h     <= mul_p;
          state <= H_F3;
        end
        H_F3: begin
          h     <= h ^ (h >> 16);
          done  <= 1'b1;
          state <= H_IDLE;
        end
        default: begin
          state <= H_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/vertex_dedup_hash_table.sv
// Channel   Handshake              Payload
// input     start / busy           command, coord_x, coord_y, coord_z
// result    done (one-cycle)       vertex_index, is_new, overflow, distinct_count
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A lookup that finds its home slot empty waits on the hash (one shared multiplier),
// then reads and checks the slot. A hit in the home slot also reads and compares
// the stored vertex; each further slot probed repeats the read, check and compare.
// A clear command sweeps the slot table one slot a cycle, then reports a result.
// After reset the same sweep runs with busy high and no result.
// Results are never stalled: done marks each result for exactly one cycle.

`include "vertex_dedup_hash_table_defines.svh"

module vertex_dedup_hash_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            command,
  input  logic [vdh_pkg::WORD_W-1:0]      coord_x,
  input  logic [vdh_pkg::WORD_W-1:0]      coord_y,
  input  logic [vdh_pkg::WORD_W-1:0]      coord_z,
  output logic                            done,
  output logic [vdh_pkg::INDEX_OUT_W-1:0] vertex_index,
  output logic                            is_new,
  output logic                            overflow,
  output logic [vdh_pkg::COUNT_OUT_W-1:0] distinct_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vdh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vdh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import vdh_pkg::*;

  // Sequencer states. SWEEP clears the slot table; after a clear command it also
  // reports a result when it finishes.
  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SWEEP    = 6'b000010,
    S_HASH     = 6'b000100,
    S_PROBE_RD = 6'b001000,
    S_SLOT_CHK = 6'b010000,
    S_VERT_CMP = 6'b100000
  } state_t;

  state_t                  state;
  logic [WORD_W-1:0]       hash_seed;
  logic [TBITS_REG_W-1:0]  table_bits;
  logic [CNT_W-1:0]        stored_total;
  logic [TABLE_BITS-1:0]   sweep_addr;
  logic                    sweep_report;
  vertex_t                 vtx;
  logic [TABLE_BITS-1:0]   probe_mask;
  logic [CNT_W-1:0]        probe_limit;
  logic [CNT_W-1:0]        probe_cnt;
  logic [CNT_W-1:0]        probe_cnt_next;
  logic [TABLE_BITS-1:0]   cur_slot;
  logic [TABLE_BITS-1:0]   hit_index;

  logic [TBITS_REG_W-1:0]  tb_eff;
  logic [CNT_W-1:0]        used_n;
  vertex_t                 vtx_in;
  logic                    accept;

  logic                    hash_start;
  logic                    hash_done;
  logic [WORD_W-1:0]       hash_val;

  logic                    slot_we;
  logic [TABLE_BITS-1:0]   slot_waddr;
  slot_entry_t             slot_wdata;
  slot_entry_t             slot_rdata;
  logic                    store_we;
  vertex_t                 store_rdata;

  // +0 and -0 fold to +0, every NaN folds to the canonical quiet NaN, so that
  // float equality of stored vertices becomes plain bit equality.
  function automatic logic [WORD_W-1:0] norm_word(input logic [WORD_W-1:0] w);
    if (w[WORD_W-2:0] == '0) begin
      return '0;
    end
    if (w[30:23] == '1 && w[22:0] != '0) begin
      return CANON_NAN;
    end
    return w;
  endfunction

  assign vtx_in.x = norm_word(coord_x);
  assign vtx_in.y = norm_word(coord_y);
  assign vtx_in.z = norm_word(coord_z);

  // Table size in use: a zero is taken as one, anything above the built size
  // is taken as the built size.
  always_comb begin
    if (table_bits == '0) begin
      tb_eff = TBITS_REG_W'(1);
    end else if (32'(table_bits) > TABLE_BITS) begin
      tb_eff = TBITS_REG_W'(TABLE_BITS);
    end else begin
      tb_eff = table_bits;
    end
  end

  assign used_n = CNT_W'(1) << tb_eff;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign hash_start = accept && command;
  // Registers only change while no item is in flight and none is being taken.
  assign cfg_ready  = !busy && !start;

  assign probe_cnt_next = probe_cnt + CNT_W'(1);

  // Slot table writes: the sweep writes empty slots, an insert fills one.
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = cur_slot;
    slot_wdata = '0;
    store_we   = 1'b0;
    if (state == S_SWEEP) begin
      slot_we    = 1'b1;
      slot_waddr = sweep_addr;
    end else if (state == S_SLOT_CHK && !slot_rdata.valid && !stored_total[TABLE_BITS]) begin
      slot_we          = 1'b1;
      slot_wdata.valid = 1'b1;
      slot_wdata.index = stored_total[TABLE_BITS-1:0];
      store_we         = 1'b1;
    end
  end

  vdh_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .seed  (hash_seed),
    .words (vtx),
    .done  (hash_done),
    .hash  (hash_val)
  );

  vdh_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (cur_slot),
    .rdata (slot_rdata)
  );

  // The store is read at the index held by the slot just read; the data comes
  // back in the compare state.
  vdh_ram #(
    .WIDTH (VERTEX_W),
    .DEPTH (SLOTS)
  ) u_store_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (stored_total[TABLE_BITS-1:0]),
    .wdata (vtx),
    .raddr (slot_rdata.index),
    .rdata (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      sweep_addr   <= '0;
      sweep_report <= 1'b0;
      stored_total <= '0;
      hash_seed    <= SEED_RESET;
      table_bits   <= TBITS_RESET;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;

      // Configuration transfers are only accepted while the block is idle.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HASH_SEED:  hash_seed <= cfg_data[WORD_W-1:0];
          REG_TABLE_BITS: table_bits <= cfg_data[TBITS_REG_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            vtx         <= vtx_in;
            probe_limit <= used_n;
            probe_mask  <= TABLE_BITS'(used_n - CNT_W'(1));
            if (command) begin
              state <= S_HASH;
            end else begin
              stored_total <= '0;
              sweep_addr   <= '0;
              sweep_report <= 1'b1;
              state        <= S_SWEEP;
            end
          end
        end

        S_SWEEP: begin
          sweep_addr <= sweep_addr + TABLE_BITS'(1);
          if (sweep_addr == '1) begin
            state <= S_IDLE;
            if (sweep_report) begin
              done           <= 1'b1;
              vertex_index   <= '0;
              is_new         <= 1'b0;
              overflow       <= 1'b0;
              distinct_count <= '0;
            end
          end
        end

        S_HASH: begin
          if (hash_done) begin
            cur_slot  <= hash_val[TABLE_BITS-1:0] & probe_mask;
            probe_cnt <= '0;
            state     <= S_PROBE_RD;
          end
        end

        S_PROBE_RD: begin
          state <= S_SLOT_CHK;
        end

        S_SLOT_CHK: begin
          if (!slot_rdata.valid) begin
            // Empty slot: the vertex is new. Insert it unless the store is full.
            done     <= 1'b1;
            state    <= S_IDLE;
            if (!stored_total[TABLE_BITS]) begin
              stored_total   <= stored_total + CNT_W'(1);
              vertex_index   <= INDEX_OUT_W'(stored_total[TABLE_BITS-1:0]);
              is_new         <= 1'b1;
              overflow       <= 1'b0;
              distinct_count <= COUNT_OUT_W'(stored_total + CNT_W'(1));
            end else begin
              vertex_index   <= '0;
              is_new         <= 1'b0;
              overflow       <= 1'b1;
              distinct_count <= COUNT_OUT_W'(stored_total);
            end
          end else begin
            hit_index <= slot_rdata.index;
            state     <= S_VERT_CMP;
          end
        end

        S_VERT_CMP: begin
          if (store_rdata == vtx) begin
            done           <= 1'b1;
            vertex_index   <= INDEX_OUT_W'(hit_index);
            is_new         <= 1'b0;
            overflow       <= 1'b0;
            distinct_count <= COUNT_OUT_W'(stored_total);
            state          <= S_IDLE;
          end else if (probe_cnt_next == probe_limit) begin
            // Every slot in use was probed without a match or a free slot.
            done           <= 1'b1;
            vertex_index   <= '0;
            is_new         <= 1'b0;
            overflow       <= 1'b1;
            distinct_count <= COUNT_OUT_W'(stored_total);
            state          <= S_IDLE;
          end else begin
            probe_cnt <= probe_cnt_next;
            cur_slot  <= (cur_slot + TABLE_BITS'(1)) & probe_mask;
            state     <= S_PROBE_RD;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted item always starts work in the next cycle.
  `VDH_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item left the block idle")
  // A result is only given as the block returns to idle.
  `VDH_ASSERT_NOW(a_done_idle, done, !busy, "result given while still busy")
  // A vertex is never both inserted and refused.
  `VDH_ASSERT_NOW(a_new_ovf, done, !(is_new && overflow), "is_new and overflow both set")
  // An inserted vertex takes the last index of the new count.
  `VDH_ASSERT_NOW(a_new_index, done && is_new,
                  distinct_count == COUNT_OUT_W'(vertex_index) + COUNT_OUT_W'(1),
                  "inserted index does not match count")

endmodule

>>> tb/vertex_dedup_hash_table_test.sv
`timescale 1ns / 100ps

// Self-checking test for the vertex deduplication hash table.
//
// Every transfer on the command channel is mirrored by a predictor that runs
// inside this module. The predictor normalizes the coordinates, hashes them
// with the murmur3 word mix and the final avalanche, and probes its own copy
// of the slot table. It then queues the answer that the block has to give.
// A monitor compares each result strobe, field by field, against the oldest
// queued answer.
//
// The stimulus runs in four parts:
//   - signed zeros, NaN payloads, infinities, denormals, hits and clears
//     under the reset configuration;
//   - a two-slot table that runs out of room, including the clamped
//     setting of zero slot bits;
//   - slot bits above the implemented size, and seed changes without a
//     clear;
//   - random traffic in phases, each with its own configuration. The sender
//     first idles often, then very often, then never.
module vertex_dedup_hash_table_test;
  import vdh_pkg::*;

  localparam bit CMD_CLEAR  = 1'b0;
  localparam bit CMD_LOOKUP = 1'b1;

  // A clear sweeps 4096 slots. Even if every item were a clear behind the
  // longest sender pause, the run would end well inside this limit.
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  // After the last result, watch this long for a stray strobe.
  localparam int TAIL_CYCLES = 64;
  // Recently seen vertices are kept so that random lookups hit often.
  localparam int POOL_DEPTH = 48;

  typedef struct packed {
    logic [INDEX_OUT_W-1:0] vertex_index;
    logic                   is_new;
    logic                   overflow;
    logic [COUNT_OUT_W-1:0] distinct_count;
  } dedup_answer_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   command;
  logic [WORD_W-1:0]      coord_x;
  logic [WORD_W-1:0]      coord_y;
  logic [WORD_W-1:0]      coord_z;
  logic                   done;
  logic [INDEX_OUT_W-1:0] vertex_index;
  logic                   is_new;
  logic                   overflow;
  logic [COUNT_OUT_W-1:0] distinct_count;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // The predictor's view of the configuration and of the table contents.
  logic [WORD_W-1:0]      seed_cfg;
  logic [TBITS_REG_W-1:0] tbits_cfg;
  bit                     slot_used [SLOTS];
  logic [TABLE_BITS-1:0]  slot_ref [SLOTS];
  logic [WORD_W-1:0]      kept_x [SLOTS];
  logic [WORD_W-1:0]      kept_y [SLOTS];
  logic [WORD_W-1:0]      kept_z [SLOTS];
  int unsigned            stored_count;

  // Answers owed by the block, oldest first.
  dedup_answer_t pending_answers[$];
  dedup_answer_t oldest_answer;
  vertex_t       seen_vertices[$];
  int            send_idle_pct;
  int unsigned   mismatches;
  int unsigned   cycle_count;

  vertex_dedup_hash_table dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .coord_z(coord_z),
    .done(done),
    .vertex_index(vertex_index),
    .is_new(is_new),
    .overflow(overflow),
    .distinct_count(distinct_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog. A hang anywhere ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Both zeros hash as +0, and every NaN hashes as the canonical quiet NaN.
  // Float equality of stored vertices then reduces to bit equality.
  function automatic logic [WORD_W-1:0] canon_word(logic [WORD_W-1:0] w);
    if (w[30:0] == '0) return '0;
    if (w[30:23] == 8'hFF && w[22:0] != '0) return CANON_NAN;
    return w;
  endfunction

  // One murmur3 body round: scramble the key word and fold it into the hash.
  function automatic logic [WORD_W-1:0] murmur_round(logic [WORD_W-1:0] k,
                                                     logic [WORD_W-1:0] h);
    k = k * 32'hCC9E_2D51;
    k = {k[16:0], k[31:17]};
    k = k * 32'h1B87_3593;
    h = h ^ k;
    h = {h[18:0], h[31:19]};
    return h * 32'd5 + 32'hE654_6B64;
  endfunction

  // The murmur3 final avalanche.
  function automatic logic [WORD_W-1:0] murmur_final(logic [WORD_W-1:0] h);
    h = h ^ (h >> 16);
    h = h * 32'h85EB_CA6B;
    h = h ^ (h >> 13);
    h = h * 32'hC2B2_AE35;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // Applies one command to the predictor state and returns the answer that
  // the block owes for it.
  function automatic dedup_answer_t resolve_vertex(bit cmd, vertex_t v);
    dedup_answer_t         a;
    logic [WORD_W-1:0]     nx;
    logic [WORD_W-1:0]     ny;
    logic [WORD_W-1:0]     nz;
    logic [WORD_W-1:0]     h;
    logic [TABLE_BITS-1:0] e;
    int unsigned           bits;
    int unsigned           span;
    int unsigned           slot;
    int unsigned           n;
    bit                    settled;
    a = '0;
    nx = canon_word(v.x);
    ny = canon_word(v.y);
    nz = canon_word(v.z);
    if (cmd == CMD_CLEAR) begin
      // The store words are kept. Only the slots and the count are reset.
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      stored_count = 0;
    end else begin
      // A zero setting acts as one bit, and anything wider than the table
      // acts as the full table.
      bits = 32'(tbits_cfg);
      if (bits < 1) bits = 1;
      if (bits > TABLE_BITS) bits = TABLE_BITS;
      span = 1 << bits;
      h = murmur_round(nx, seed_cfg);
      h = murmur_round(ny, h);
      h = murmur_round(nz, h);
      slot = murmur_final(h) & (span - 1);
      settled = 1'b0;
      // Linear probing visits each slot in use at most once.
      for (n = 0; n < span && !settled; n++) begin
        if (!slot_used[slot]) begin
          if (stored_count < SLOTS) begin
            kept_x[stored_count] = nx;
            kept_y[stored_count] = ny;
            kept_z[stored_count] = nz;
            slot_used[slot] = 1'b1;
            slot_ref[slot] = TABLE_BITS'(stored_count);
            a.vertex_index = INDEX_OUT_W'(stored_count);
            a.is_new = 1'b1;
            stored_count++;
          end else begin
            a.overflow = 1'b1;
          end
          settled = 1'b1;
        end else begin
          e = slot_ref[slot];
          if (kept_x[e] == nx && kept_y[e] == ny && kept_z[e] == nz) begin
            a.vertex_index = INDEX_OUT_W'(e);
            settled = 1'b1;
          end else begin
            slot = (slot + 1) & (span - 1);
          end
        end
      end
      // Every probed slot was taken by some other vertex.
      if (!settled) a.overflow = 1'b1;
    end
    a.distinct_count = COUNT_OUT_W'(stored_count);
    return a;
  endfunction

  // ---------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // The receiver cannot stall, so every strobe is a completed transfer.
  // Outputs are sampled at the edge that ends the strobe cycle.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result with no command outstanding, vertex_index %0d is_new %0b",
                 $time, vertex_index, is_new);
        mismatches++;
      end else begin
        oldest_answer = pending_answers.pop_front();
        report_field("vertex_index", 32'(oldest_answer.vertex_index), 32'(vertex_index));
        report_field("is_new", 32'(oldest_answer.is_new), 32'(is_new));
        report_field("overflow", 32'(oldest_answer.overflow), 32'(overflow));
        report_field("distinct_count", 32'(oldest_answer.distinct_count),
                     32'(distinct_count));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Draws a coordinate, weighted toward the encodings that the hash treats
  // specially and toward a few repeated values so that vertices share words.
  function automatic logic [WORD_W-1:0] random_coord();
    logic [WORD_W-1:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0: w = {w[31], 31'd0};
      1: w = {w[31], 8'hFF, 23'd0};
      2: w = {w[31], 8'hFF, w[22:1], 1'b1};
      3: w = {w[31], 8'h00, w[22:0]};
      4: w = {1'b0, 8'h3F, w[22:21], 21'd0};
      default: ;
    endcase
    return w;
  endfunction

  function automatic vertex_t random_vertex();
    return {random_coord(), random_coord(), random_coord()};
  endfunction

  // Returns another encoding that compares equal: a zero with a random sign,
  // or a NaN with a random sign and payload.
  function automatic logic [WORD_W-1:0] alias_coord(logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] r;
    r = $urandom;
    if (w[30:0] == '0) return {r[31], 31'd0};
    if (w[30:23] == 8'hFF && w[22:0] != '0) begin
      if (r[22:0] == '0) r[0] = 1'b1;
      return {r[31], 8'hFF, r[22:0]};
    end
    return w;
  endfunction

  // Offers one command and waits for its transfer. Start is left high, so
  // back-to-back commands keep the line asserted. Any other activity lowers
  // it first.
  task automatic send_item(bit cmd, vertex_t v);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    coord_x <= v.x;
    coord_y <= v.y;
    coord_z <= v.z;
    do @(posedge clk); while (busy !== 1'b0);
    pending_answers.push_back(resolve_vertex(cmd, v));
  endtask

  // Stops sending and waits until every owed answer has arrived and the
  // block reports idle. This also covers the slot sweep after reset.
  task automatic settle_block();
    start <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0 || busy !== 1'b0);
  endtask

  // Writes one register. Valid stays high on return, so a second write can
  // follow directly.
  task automatic put_register(cfg_idx_t which, logic [CFG_DATA_W-1:0] value);
    cfg_index <= which;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (which == REG_HASH_SEED) seed_cfg = value;
    else tbits_cfg = value[TBITS_REG_W-1:0];
  endtask

  // Registers change only while the block is idle.
  task automatic write_config(bit set_seed, logic [CFG_DATA_W-1:0] seed_word,
                              bit set_bits, logic [CFG_DATA_W-1:0] bits_word);
    settle_block();
    if (set_seed) put_register(REG_HASH_SEED, seed_word);
    if (set_bits) put_register(REG_TABLE_BITS, bits_word);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Uses the reset configuration. Each group of encodings must collapse to
  // one vertex, and a clear must restart the numbering.
  task automatic test_zero_nan_and_clear();
    send_idle_pct = 34;
    send_item(CMD_LOOKUP, {32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
    // Negative zeros must find the vertex stored above.
    send_item(CMD_LOOKUP, {32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    // All ones is a negative NaN. It becomes the canonical NaN.
    send_item(CMD_LOOKUP, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_item(CMD_LOOKUP, {32'h7FC0_0000, 32'h7F80_0001, 32'hFF80_0001});
    send_item(CMD_LOOKUP, {32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF});
    send_item(CMD_LOOKUP, {32'h0000_0001, 32'h8000_0001, 32'h3F80_0000});
    send_item(CMD_LOOKUP, {32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF});
    send_item(CMD_CLEAR, {32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF});
    // After the clear, old vertices are inserted again from index zero.
    send_item(CMD_LOOKUP, {32'h0000_0001, 32'h8000_0001, 32'h3F80_0000});
    send_item(CMD_LOOKUP, {32'h8000_0000, 32'h0000_0000, 32'h8000_0000});
  endtask

  // A one-bit table has two slots. A third distinct vertex cannot be placed,
  // but the vertices already stored are still found.
  task automatic test_tiny_table_overflow();
    write_config(1'b1, 32'h0000_0000, 1'b1, 32'd1);
    send_item(CMD_CLEAR, random_vertex());
    send_item(CMD_LOOKUP, {32'h3F80_0000, 32'h0000_0000, 32'h0000_0000});
    send_item(CMD_LOOKUP, {32'h0000_0000, 32'h3F80_0000, 32'h0000_0000});
    send_item(CMD_LOOKUP, {32'h0000_0000, 32'h0000_0000, 32'h3F80_0000});
    send_item(CMD_LOOKUP, {32'hBF80_0000, 32'h0000_0000, 32'h0000_0000});
    send_item(CMD_LOOKUP, {32'h3F80_0000, 32'h8000_0000, 32'h0000_0000});
    // A zero setting, with the unused upper data bits set, behaves as one bit.
    write_config(1'b0, '0, 1'b1, 32'hFFFF_FFF0);
    send_item(CMD_LOOKUP, {32'h0000_0000, 32'h3F80_0000, 32'h0000_0000});
    send_item(CMD_LOOKUP, {32'h0000_0000, 32'h0000_0000, 32'h3F80_0000});
  endtask

  // Settings above the table size are clamped. A seed change without a
  // clear may store an existing vertex a second time.
  task automatic test_clamped_table_bits();
    write_config(1'b1, 32'hFFFF_FFFF, 1'b1, 32'd15);
    send_item(CMD_CLEAR, random_vertex());
    send_item(CMD_LOOKUP, {32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0080_0000});
    send_item(CMD_LOOKUP, {32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0080_0000});
    write_config(1'b1, 32'h0000_0000, 1'b1, 32'd13);
    send_item(CMD_LOOKUP, {32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0080_0000});
    send_item(CMD_LOOKUP, {32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000});
  endtask

  // Random phases. Each phase waits for the block to drain, picks a new
  // configuration (extremes included), usually clears, and then sends a
  // batch of lookups. About half of the lookups reuse a recent vertex under
  // an equivalent encoding, so hits are common. Rare clears fall inside the
  // batch.
  task automatic test_random_traffic(int unsigned items, int idle_pct);
    int unsigned       left;
    int unsigned       batch;
    int                pick;
    bit                set_seed;
    bit                set_bits;
    logic [WORD_W-1:0] seed_word;
    logic [WORD_W-1:0] bits_word;
    vertex_t           v;
    send_idle_pct = idle_pct;
    left = items;
    while (left > 0) begin
      set_seed = 1'($urandom_range(1));
      case ($urandom_range(3))
        0: seed_word = '0;
        1: seed_word = '1;
        default: seed_word = $urandom;
      endcase
      bits_word = $urandom;
      set_bits = 1'b1;
      pick = $urandom_range(19);
      if (pick == 0) bits_word[TBITS_REG_W-1:0] = 4'd0;
      else if (pick <= 4) bits_word[TBITS_REG_W-1:0] = 4'($urandom_range(1, 3));
      else if (pick <= 10) bits_word[TBITS_REG_W-1:0] = 4'($urandom_range(4, 11));
      else if (pick <= 14) bits_word[TBITS_REG_W-1:0] = 4'd12;
      else if (pick <= 16) bits_word[TBITS_REG_W-1:0] = 4'($urandom_range(13, 15));
      else set_bits = 1'b0;
      // The block is drained here, which also gives the sender a full pause.
      write_config(set_seed, seed_word, set_bits, bits_word);
      if ($urandom_range(9) < 7) begin
        send_item(CMD_CLEAR, random_vertex());
        left--;
      end
      batch = $urandom_range(20, 60);
      while (batch > 0 && left > 0) begin
        if ($urandom_range(99) < 2) begin
          send_item(CMD_CLEAR, random_vertex());
        end else begin
          if (seen_vertices.size() > 0 && $urandom_range(99) < 55) begin
            v = seen_vertices[$urandom_range(seen_vertices.size() - 1)];
            v.x = alias_coord(v.x);
            v.y = alias_coord(v.y);
            v.z = alias_coord(v.z);
          end else begin
            v = random_vertex();
            seen_vertices.push_back(v);
            if (seen_vertices.size() > POOL_DEPTH) void'(seen_vertices.pop_front());
          end
          send_item(CMD_LOOKUP, v);
        end
        batch--;
        left--;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    command <= CMD_CLEAR;
    coord_x <= '0;
    coord_y <= '0;
    coord_z <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_HASH_SEED;
    cfg_data <= '0;
    seed_cfg = SEED_RESET;
    tbits_cfg = TBITS_RESET;
    stored_count = 0;
    mismatches = 0;
    send_idle_pct = 0;
    foreach (slot_used[i]) begin
      slot_used[i] = 1'b0;
      slot_ref[i] = '0;
      kept_x[i] = '0;
      kept_y[i] = '0;
      kept_z[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_zero_nan_and_clear();
    test_tiny_table_overflow();
    test_clamped_table_bits();
    test_random_traffic(380, 34);
    test_random_traffic(380, 86);
    test_random_traffic(380, 0);

    // Collect the last answers, then watch a while for anything extra.
    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
